// ===== hw/rtl/multitouch_gesture_event_generator_core_assert.svh =====
// Assertion helpers for the gesture event generator.
`ifndef MULTITOUCH_GESTURE_EVENT_GENERATOR_CORE_ASSERT_SVH
`define MULTITOUCH_GESTURE_EVENT_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MTGEG_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MTGEG_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MTGEG_ASSERT_RST(label, prop, msg)
`define MTGEG_ASSERT_CLK(label, prop, msg)
`endif
`endif

// ===== hw/rtl/mtgeg_pkg.sv =====
package mtgeg_pkg;

   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 16;
   localparam int COORD_W    = 16;
   localparam int VALUE_W    = 18;
   localparam int CSR_IDX_W  = 1;

   localparam logic [VALUE_W-1:0] PRESSURE_VALUE = 18'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_PROTOCOL_KIND    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACKING_ID_BASE = 1'b1;

   localparam logic [1:0] GEST_HOLD         = 2'd0;
   localparam logic [1:0] GEST_MOVE_HOLD    = 2'd1;
   localparam logic [1:0] GEST_MOVE_RELEASE = 2'd2;

   localparam logic PROTO_ANON    = 1'b0;

   typedef enum logic [1:0] {
      MODE_DOWN    = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_MOVE    = 2'd2,
      MODE_RELEASE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      EV_PRESSURE    = 3'd0,
      EV_POS_X       = 3'd1,
      EV_POS_Y       = 3'd2,
      EV_TRACK       = 3'd3,
      EV_CONTACT_END = 3'd4,
      EV_FRAME_END   = 3'd5,
      EV_BUTTON      = 3'd6,
      EV_SLOT_SEL    = 3'd7
   } ev_kind_type;

   typedef enum logic [2:0] {
      VS_ZERO  = 3'd0,
      VS_ONE   = 3'd1,
      VS_PRESS = 3'd2,
      VS_NOWX  = 3'd3,
      VS_NOWY  = 3'd4,
      VS_IDX   = 3'd5,
      VS_TRACK = 3'd6,
      VS_LIFT  = 3'd7
   } val_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD  = 2'd0,
      PTR_ZERO  = 2'd1,
      PTR_FOUND = 2'd2,
      PTR_INC   = 2'd3
   } ptr_sel_type;

   typedef struct packed {
      logic        capture;
      ptr_sel_type ptr_sel;
      logic        set_grant;
      logic        claim;
      logic        act_inc;
      logic        act_dec;
      logic        free;
      logic        write_move;
      logic        write_step;
      logic        clr_gesture;
      logic        mul;
      logic        div_start;
      logic        keep;
      logic        sel_y;
      logic        emit;
      ev_kind_type ev_kind;
      val_sel_type val_sel;
   } dp_cmd_type;

   typedef struct packed {
      mode_type   mode;
      logic       slot_ok;
      logic       proto;
      logic       found_ok;
      logic       busy_at;
      logic [1:0] gesture_at;
      logic       step_less;
      logic       ptr_last;
      logic       act_one;
      logic       act_zero;
      logic       div_busy;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/mtgeg_div.sv =====
module mtgeg_div import mtgeg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fit;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fit     = shifted >= {1'b0, divisor};
   assign trial   = shifted - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fit};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/mtgeg_dp.sv =====
module mtgeg_dp import mtgeg_pkg::*; #(
   parameter int SLOT_COUNT = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_mode,
   input  logic [3:0]                  req_slot,
   input  logic [COORD_W-1:0]          req_begin_x,
   input  logic [COORD_W-1:0]          req_begin_y,
   input  logic [COORD_W-1:0]          req_target_x,
   input  logic [COORD_W-1:0]          req_target_y,
   input  logic [COORD_W-1:0]          req_step_total,
   input  logic [1:0]                  req_gesture,
   input  logic [COORD_W-1:0]          req_move_x,
   input  logic [COORD_W-1:0]          req_move_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_event_kind,
   output logic signed [VALUE_W-1:0]   rsp_event_value,
   output logic                        rsp_last,
   output logic [3:0]                  rsp_granted_slot,
   output logic                        rsp_no_free_slot,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COORD_W-1:0]          csr_data,
   input  dp_cmd_type                  cmd,
   output dp_status_type               status
);

   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic                 proto_ff;
   logic [COORD_W-1:0]   base_ff;
   mode_type             mode_ff;
   logic [3:0]           slot_ff;
   logic [COORD_W-1:0]   bx_ff, by_ff, tx_ff, ty_ff, steps_ff, mx_ff, my_ff;
   logic [1:0]           gest_in_ff;
   logic [SW-1:0]        ptr_ff;
   logic [SLOT_COUNT-1:0] busy_ff;
   logic [1:0]           gest_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   start_x_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   start_y_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   end_x_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   end_y_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   now_x_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   now_y_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   total_ff [SLOT_COUNT];
   logic [COORD_W-1:0]   done_ff [SLOT_COUNT];
   logic [3:0]           active_ff;
   logic [3:0]           grant_ff;
   logic                 nofree_ff;
   logic signed [33:0]   prod_ff;
   logic signed [33:0]   prod_in;
   logic [COORD_W-1:0]   ix_ff, iy_ff;
   logic                 out_valid_ff;
   ev_kind_type          out_kind_ff;
   logic [VALUE_W-1:0]   out_value_ff;
   logic                 out_last_ff;
   logic [3:0]           out_grant_ff;
   logic                 out_nofree_ff;

   logic [SW-1:0]        found;
   logic                 found_ok;
   logic [COORD_W-1:0]   s_sel, e_sel, k_val, offset, interp;
   logic signed [16:0]   diff;
   logic [33:0]          magn;
   logic                 neg;
   logic                 div_busy;
   logic [DIVIDEND_W-1:0] quotient;
   logic [VALUE_W-1:0]   value;
   logic                 out_free;

   // lowest free slot
   always_comb begin
      found    = '0;
      found_ok = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            found    = SW'(i);
            found_ok = 1'b1;
         end
      end
   end

   assign s_sel  = cmd.sel_y ? start_y_ff[ptr_ff] : start_x_ff[ptr_ff];
   assign e_sel  = cmd.sel_y ? end_y_ff[ptr_ff] : end_x_ff[ptr_ff];
   assign k_val  = done_ff[ptr_ff] + COORD_W'(1);
   assign diff   = $signed({1'b0, e_sel}) - $signed({1'b0, s_sel});
   assign prod_in = diff * $signed({1'b0, k_val});
   assign neg    = prod_ff[33];
   assign magn   = neg ? (34'd0 - prod_ff) : prod_ff;
   assign offset = neg ? (COORD_W'(0) - quotient[COORD_W-1:0]) : quotient[COORD_W-1:0];
   assign interp = s_sel + offset;

   mtgeg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (magn[DIVIDEND_W-1:0]),
      .divisor  (total_ff[ptr_ff]),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      unique case (cmd.val_sel)
         VS_ZERO:  value = '0;
         VS_ONE:   value = VALUE_W'(1);
         VS_PRESS: value = PRESSURE_VALUE;
         VS_NOWX:  value = VALUE_W'(now_x_ff[ptr_ff]);
         VS_NOWY:  value = VALUE_W'(now_y_ff[ptr_ff]);
         VS_IDX:   value = VALUE_W'(ptr_ff);
         VS_TRACK: value = VALUE_W'({1'b0, base_ff} + 17'(ptr_ff));
         VS_LIFT:  value = '1;
         default:  value = '0;
      endcase
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff     <= 1'b0;
         base_ff      <= '0;
         busy_ff      <= '0;
         active_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            gest_ff[i] <= GEST_HOLD;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_PROTOCOL_KIND:    proto_ff <= csr_data[0];
               CSR_TRACKING_ID_BASE: base_ff  <= csr_data;
               default:              base_ff  <= base_ff;
            endcase
         end
         if (cmd.claim) begin
            busy_ff[found] <= 1'b1;
            gest_ff[found] <= gest_in_ff;
         end
         if (cmd.free) begin
            busy_ff[ptr_ff] <= 1'b0;
         end
         if (cmd.clr_gesture) begin
            gest_ff[ptr_ff] <= GEST_HOLD;
         end
         if (cmd.act_inc) begin
            active_ff <= active_ff + 4'd1;
         end else if (cmd.act_dec) begin
            active_ff <= active_ff - 4'd1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= mode_type'(req_mode);
         slot_ff    <= req_slot;
         bx_ff      <= req_begin_x;
         by_ff      <= req_begin_y;
         tx_ff      <= req_target_x;
         ty_ff      <= req_target_y;
         steps_ff   <= req_step_total;
         gest_in_ff <= req_gesture;
         mx_ff      <= req_move_x;
         my_ff      <= req_move_y;
         ptr_ff     <= req_slot[SW-1:0];
         grant_ff   <= '0;
         nofree_ff  <= 1'b0;
      end else begin
         unique case (cmd.ptr_sel)
            PTR_HOLD:  ptr_ff <= ptr_ff;
            PTR_ZERO:  ptr_ff <= '0;
            PTR_FOUND: ptr_ff <= found;
            PTR_INC:   ptr_ff <= ptr_ff + SW'(1);
            default:   ptr_ff <= ptr_ff;
         endcase
      end
      if (cmd.set_grant) begin
         grant_ff  <= found_ok ? 4'(found) : 4'd0;
         nofree_ff <= !found_ok;
      end
      if (cmd.claim) begin
         start_x_ff[found] <= bx_ff;
         start_y_ff[found] <= by_ff;
         end_x_ff[found]   <= tx_ff;
         end_y_ff[found]   <= ty_ff;
         now_x_ff[found]   <= bx_ff;
         now_y_ff[found]   <= by_ff;
         total_ff[found]   <= steps_ff;
         done_ff[found]    <= '0;
      end
      if (cmd.write_move) begin
         now_x_ff[ptr_ff] <= mx_ff;
         now_y_ff[ptr_ff] <= my_ff;
      end
      if (cmd.write_step) begin
         now_x_ff[ptr_ff] <= ix_ff;
         now_y_ff[ptr_ff] <= iy_ff;
         done_ff[ptr_ff]  <= k_val;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.keep) begin
         if (cmd.sel_y) begin
            iy_ff <= interp;
         end else begin
            ix_ff <= interp;
         end
      end
      // grant fields travel with the word so a stalled word stays put
      if (cmd.emit) begin
         out_kind_ff   <= cmd.ev_kind;
         out_value_ff  <= value;
         out_last_ff   <= (cmd.ev_kind == EV_FRAME_END);
         out_grant_ff  <= grant_ff;
         out_nofree_ff <= nofree_ff;
      end
   end

   assign status.mode       = mode_ff;
   assign status.slot_ok    = slot_ff < 4'(SLOT_COUNT);
   assign status.proto      = proto_ff;
   assign status.found_ok   = found_ok;
   assign status.busy_at    = busy_ff[ptr_ff];
   assign status.gesture_at = gest_ff[ptr_ff];
   assign status.step_less  = done_ff[ptr_ff] < total_ff[ptr_ff];
   assign status.ptr_last   = ptr_ff == SW'(SLOT_COUNT - 1);
   assign status.act_one    = active_ff == 4'd1;
   assign status.act_zero   = active_ff == 4'd0;
   assign status.div_busy   = div_busy;
   assign status.out_free   = out_free;

   assign csr_ready        = 1'b1;
   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_event_value  = $signed(out_value_ff);
   assign rsp_last         = out_last_ff;
   assign rsp_granted_slot = out_grant_ff;
   assign rsp_no_free_slot = out_nofree_ff;

endmodule

// ===== hw/rtl/mtgeg_ctrl.sv =====
module mtgeg_ctrl import mtgeg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_MUL_X, ST_DIV_X, ST_WAIT_X, ST_MUL_Y, ST_DIV_Y,
      ST_WAIT_Y, ST_COMMIT, ST_SCAN, ST_C_PRESS, ST_C_X, ST_C_Y, ST_C_TRK,
      ST_C_END, ST_E_SEL, ST_E_TRACK, ST_E_X, ST_E_Y, ST_E_PRESS, ST_E_LIFT,
      ST_E_CEND, ST_E_BTN1, ST_E_BTN0, ST_E_FRAME
   } state_type;

   typedef enum logic [1:0] {
      RUN_DOWN, RUN_MOVE, RUN_REL
   } run_type;

   state_type state_ff, state_in, tail;
   run_type   run_ff, run_in;
   logic      rel_go, step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_ff   <= RUN_DOWN;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
      end
   end

   // closing events of an anonymous run
   always_comb begin
      unique case (run_ff)
         RUN_DOWN: tail = status.act_one ? ST_E_BTN1 : ST_E_FRAME;
         RUN_REL:  tail = status.act_zero ? ST_E_CEND : ST_E_FRAME;
         default:  tail = ST_E_FRAME;
      endcase
   end

   assign step_go = status.busy_at && (status.gesture_at != GEST_HOLD) && status.step_less;
   assign rel_go  = (status.mode == MODE_RELEASE) ||
                    ((status.mode == MODE_ADVANCE) && status.busy_at && !status.step_less &&
                     (status.gesture_at == GEST_MOVE_RELEASE));

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      run_in   = run_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (status.mode == MODE_DOWN) begin
               cmd.set_grant = 1'b1;
               run_in        = RUN_DOWN;
               if (status.proto == PROTO_ANON) begin
                  cmd.claim   = status.found_ok;
                  cmd.act_inc = status.found_ok;
                  cmd.ptr_sel = PTR_ZERO;
                  state_in    = ST_SCAN;
               end else if (status.found_ok) begin
                  cmd.claim   = 1'b1;
                  cmd.ptr_sel = PTR_FOUND;
                  state_in    = ST_E_SEL;
               end
            end else if (!status.slot_ok) begin
               state_in = ST_IDLE;
            end else if (status.mode == MODE_MOVE) begin
               cmd.write_move = 1'b1;
               run_in         = RUN_MOVE;
               if (status.proto == PROTO_ANON) begin
                  cmd.ptr_sel = PTR_ZERO;
                  state_in    = ST_SCAN;
               end else if (status.busy_at) begin
                  state_in = ST_E_SEL;
               end
            end else if (rel_go) begin
               run_in = RUN_REL;
               if (status.proto == PROTO_ANON) begin
                  cmd.free    = status.busy_at;
                  cmd.act_dec = status.busy_at;
                  cmd.ptr_sel = PTR_ZERO;
                  state_in    = ST_SCAN;
               end else if (status.busy_at) begin
                  cmd.free = 1'b1;
                  state_in = ST_E_SEL;
               end
            end else if (step_go) begin
               state_in = ST_MUL_X;
            end else if (status.busy_at && (status.gesture_at == GEST_MOVE_HOLD)) begin
               cmd.clr_gesture = 1'b1;
            end
         end
         ST_MUL_X: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (!status.div_busy) begin
               cmd.keep = 1'b1;
               state_in = ST_MUL_Y;
            end
         end
         ST_MUL_Y: begin
            cmd.mul   = 1'b1;
            cmd.sel_y = 1'b1;
            state_in  = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.div_start = 1'b1;
            cmd.sel_y     = 1'b1;
            state_in      = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            cmd.sel_y = 1'b1;
            if (!status.div_busy) begin
               cmd.keep = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.write_step = 1'b1;
            run_in         = RUN_MOVE;
            if (status.proto == PROTO_ANON) begin
               cmd.ptr_sel = PTR_ZERO;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_E_SEL;
            end
         end
         ST_SCAN: begin
            if (status.busy_at) begin
               state_in = ST_C_PRESS;
            end else if (status.ptr_last) begin
               state_in = tail;
            end else begin
               cmd.ptr_sel = PTR_INC;
            end
         end
         ST_C_PRESS, ST_C_X, ST_C_Y, ST_C_TRK, ST_C_END,
         ST_E_SEL, ST_E_TRACK, ST_E_X, ST_E_Y, ST_E_PRESS, ST_E_LIFT,
         ST_E_CEND, ST_E_BTN1, ST_E_BTN0, ST_E_FRAME: begin
            cmd.emit = status.out_free;
            unique case (state_ff)
               ST_C_PRESS: begin
                  cmd.ev_kind = EV_PRESSURE;    cmd.val_sel = VS_PRESS;
                  state_in = ST_C_X;
               end
               ST_C_X: begin
                  cmd.ev_kind = EV_POS_X;       cmd.val_sel = VS_NOWX;
                  state_in = ST_C_Y;
               end
               ST_C_Y: begin
                  cmd.ev_kind = EV_POS_Y;       cmd.val_sel = VS_NOWY;
                  state_in = ST_C_TRK;
               end
               ST_C_TRK: begin
                  cmd.ev_kind = EV_TRACK;       cmd.val_sel = VS_IDX;
                  state_in = ST_C_END;
               end
               ST_C_END: begin
                  cmd.ev_kind = EV_CONTACT_END; cmd.val_sel = VS_ZERO;
                  if (status.ptr_last) begin
                     state_in = tail;
                  end else begin
                     cmd.ptr_sel = status.out_free ? PTR_INC : PTR_HOLD;
                     state_in    = ST_SCAN;
                  end
               end
               ST_E_SEL: begin
                  cmd.ev_kind = EV_SLOT_SEL;    cmd.val_sel = VS_IDX;
                  unique case (run_ff)
                     RUN_DOWN: state_in = ST_E_TRACK;
                     RUN_REL:  state_in = ST_E_LIFT;
                     default:  state_in = ST_E_X;
                  endcase
               end
               ST_E_TRACK: begin
                  cmd.ev_kind = EV_TRACK;       cmd.val_sel = VS_TRACK;
                  state_in = ST_E_X;
               end
               ST_E_X: begin
                  cmd.ev_kind = EV_POS_X;       cmd.val_sel = VS_NOWX;
                  state_in = ST_E_Y;
               end
               ST_E_Y: begin
                  cmd.ev_kind = EV_POS_Y;       cmd.val_sel = VS_NOWY;
                  state_in = ST_E_PRESS;
               end
               ST_E_PRESS: begin
                  cmd.ev_kind = EV_PRESSURE;    cmd.val_sel = VS_PRESS;
                  state_in = ST_E_FRAME;
               end
               ST_E_LIFT: begin
                  cmd.ev_kind = EV_TRACK;       cmd.val_sel = VS_LIFT;
                  state_in = ST_E_FRAME;
               end
               ST_E_CEND: begin
                  cmd.ev_kind = EV_CONTACT_END; cmd.val_sel = VS_ZERO;
                  state_in = ST_E_BTN0;
               end
               ST_E_BTN1: begin
                  cmd.ev_kind = EV_BUTTON;      cmd.val_sel = VS_ONE;
                  state_in = ST_E_FRAME;
               end
               ST_E_BTN0: begin
                  cmd.ev_kind = EV_BUTTON;      cmd.val_sel = VS_ZERO;
                  state_in = ST_E_FRAME;
               end
               default: begin
                  cmd.ev_kind = EV_FRAME_END;   cmd.val_sel = VS_ZERO;
                  state_in = ST_IDLE;
               end
            endcase
            // stalled output: hold everything
            if (!status.out_free) begin
               state_in    = state_ff;
               cmd.ptr_sel = PTR_HOLD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// ===== hw/rtl/multitouch_gesture_event_generator_core.sv =====
// channel  | handshake                 | words
// req_     | req_valid / req_stall     | one command (down, advance, move, release)
// rsp_     | rsp_valid / rsp_stall     | one report event, rsp_last on the frame end
// csr_     | csr_valid / csr_ready     | register index and data, always ready
//
// One command at a time: it is captured and decoded, then the anonymous scan
// walks the slots and events go out one by one (up to 5*SLOT_COUNT+2 events).
// Advance with a step interpolates x then y on one 32-step shift-subtract
// divider (multiply, divide, wait per axis), then writes both back to the slot.
// Reset is synchronous; slot stores need no clearing pass.
// A stalled rsp_ word holds the sequencer in place; req_stall stays high until
// the frame end is handed to the output register, or a silent command is decoded.
`include "multitouch_gesture_event_generator_core_assert.svh"
module multitouch_gesture_event_generator_core import mtgeg_pkg::*; #(
   parameter int SLOT_COUNT = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_mode,
   input  logic [3:0]                 req_slot,
   input  logic [15:0]                req_begin_x,
   input  logic [15:0]                req_begin_y,
   input  logic [15:0]                req_target_x,
   input  logic [15:0]                req_target_y,
   input  logic [15:0]                req_step_total,
   input  logic [1:0]                 req_gesture,
   input  logic [15:0]                req_move_x,
   input  logic [15:0]                req_move_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_event_kind,
   output logic signed [17:0]         rsp_event_value,
   output logic                       rsp_last,
   output logic [3:0]                 rsp_granted_slot,
   output logic                       rsp_no_free_slot,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [15:0]                csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mtgeg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   mtgeg_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_begin_x      (req_begin_x),
      .req_begin_y      (req_begin_y),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_step_total   (req_step_total),
      .req_gesture      (req_gesture),
      .req_move_x       (req_move_x),
      .req_move_y       (req_move_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_value  (rsp_event_value),
      .rsp_last         (rsp_last),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_no_free_slot (rsp_no_free_slot),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (dp_cmd),
      .status           (dp_status)
   );

   `MTGEG_ASSERT_RST(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "accept did not block")
   `MTGEG_ASSERT_RST(a_emit_needs_room, dp_cmd.emit |-> dp_status.out_free, "event overwrote output")
   `MTGEG_ASSERT_RST(a_last_is_frame, (rsp_valid && rsp_last) |-> (rsp_event_kind == EV_FRAME_END), "last not frame end")
   `MTGEG_ASSERT_RST(a_nofree_grant, (rsp_valid && rsp_no_free_slot) |-> (rsp_granted_slot == 4'd0), "grant with no free slot")

endmodule

// ===== tb/tb_multitouch_gesture_event_generator_core.sv =====
`default_nettype none
module tb_multitouch_gesture_event_generator_core;
   import mtgeg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 9;
   // longest command plus the divider, with margin
   localparam int QUIET_CYCLES = 400;

   typedef struct {
      mode_type    mode;
      logic [3:0]  slot;
      logic [15:0] bx, by, tx, ty, steps;
      logic [1:0]  gesture;
      logic [15:0] mx, my;
   } cmd_t;

   typedef struct {
      ev_kind_type kind;
      logic [17:0] value;
      logic        last;
      logic [3:0]  granted;
      logic        nofree;
   } event_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [1:0] req_mode, req_gesture;
   logic [3:0] req_slot;
   logic [15:0] req_begin_x, req_begin_y, req_target_x, req_target_y;
   logic [15:0] req_step_total, req_move_x, req_move_y;
   logic rsp_valid, rsp_stall;
   logic [2:0] rsp_event_kind;
   logic signed [17:0] rsp_event_value;
   logic rsp_last, rsp_no_free_slot;
   logic [3:0] rsp_granted_slot;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0] csr_data;

   multitouch_gesture_event_generator_core #(.SLOT_COUNT(NSLOT)) u_dut (.*);

   always #5 clock = ~clock;

   // gesture engine mirror
   logic        proto;
   logic [15:0] id_base;
   logic        busy [NSLOT];
   logic [1:0]  gest [NSLOT];
   logic [15:0] sx [NSLOT], sy [NSLOT], ex [NSLOT], ey [NSLOT];
   logic [15:0] nx [NSLOT], ny [NSLOT], nsteps [NSLOT], ndone [NSLOT];
   logic [3:0]  contacts;
   logic [3:0]  run_granted;
   logic        run_nofree;

   event_t event_q[$];
   int     fail_count = 0;
   int     words_checked = 0;
   int     cmds_sent = 0;
   bit     steady = 0;
   int     stall_left = 0;

   function automatic void push_event(ev_kind_type k, logic [17:0] v);
      event_t e;
      e.kind = k; e.value = v; e.last = 1'b0;
      e.granted = run_granted; e.nofree = run_nofree;
      event_q.push_back(e);
   endfunction

   function automatic void push_contact(int i, logic [15:0] x, logic [15:0] y);
      push_event(EV_PRESSURE, PRESSURE_VALUE);
      push_event(EV_POS_X, {2'b0, x});
      push_event(EV_POS_Y, {2'b0, y});
      push_event(EV_TRACK, 18'(i));
      push_event(EV_CONTACT_END, '0);
   endfunction

   function automatic void apply_move(int id, logic [15:0] x, logic [15:0] y);
      nx[id] = x; ny[id] = y;
      if (proto == PROTO_ANON) begin
         for (int i = 0; i < NSLOT; i++)
            if (busy[i]) push_contact(i, nx[i], ny[i]);
         push_event(EV_FRAME_END, '0);
      end else if (busy[id]) begin
         push_event(EV_SLOT_SEL, 18'(id));
         push_event(EV_POS_X, {2'b0, x});
         push_event(EV_POS_Y, {2'b0, y});
         push_event(EV_PRESSURE, PRESSURE_VALUE);
         push_event(EV_FRAME_END, '0);
      end
   endfunction

   function automatic void apply_release(int id);
      if (proto == PROTO_ANON) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (busy[i]) begin
               if (i == id) begin
                  contacts--;
                  busy[i] = 1'b0;
               end else begin
                  push_contact(i, nx[i], ny[i]);
               end
            end
         end
         if (contacts == 0) begin
            push_event(EV_CONTACT_END, '0);
            push_event(EV_BUTTON, '0);
         end
         push_event(EV_FRAME_END, '0);
      end else if (busy[id]) begin
         busy[id] = 1'b0;
         push_event(EV_SLOT_SEL, 18'(id));
         push_event(EV_TRACK, '1);
         push_event(EV_FRAME_END, '0);
      end
   endfunction

   function automatic void claim_slot(int i, cmd_t c);
      busy[i] = 1'b1; gest[i] = c.gesture;
      sx[i] = c.bx; sy[i] = c.by; ex[i] = c.tx; ey[i] = c.ty;
      nsteps[i] = c.steps; ndone[i] = '0;
      nx[i] = c.bx; ny[i] = c.by;
   endfunction

   function automatic void apply_down(cmd_t c);
      int found = -1;
      for (int i = 0; i < NSLOT; i++)
         if (!busy[i] && found < 0) found = i;
      run_granted = (found >= 0) ? 4'(found) : 4'd0;
      run_nofree = (found < 0);
      if (proto == PROTO_ANON) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (busy[i]) begin
               push_contact(i, nx[i], ny[i]);
            end else if (i == found) begin
               contacts++;
               claim_slot(i, c);
               push_contact(i, sx[i], sy[i]);
            end
         end
         if (contacts == 1) push_event(EV_BUTTON, 18'd1);
         push_event(EV_FRAME_END, '0);
      end else if (found >= 0) begin
         claim_slot(found, c);
         push_event(EV_SLOT_SEL, 18'(found));
         push_event(EV_TRACK, 18'(id_base) + 18'(found));
         push_event(EV_POS_X, {2'b0, sx[found]});
         push_event(EV_POS_Y, {2'b0, sy[found]});
         push_event(EV_PRESSURE, PRESSURE_VALUE);
         push_event(EV_FRAME_END, '0);
      end
   endfunction

   // start + (end - start) * k / n, truncating toward zero
   function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b,
                                        logic [15:0] k, logic [15:0] n);
      longint d;
      d = (longint'(b) - longint'(a)) * longint'(k);
      return 16'(longint'(a) + d / longint'(n));
   endfunction

   function automatic void apply_advance(int i);
      logic [15:0] k;
      if (!busy[i] || gest[i] == GEST_HOLD) return;
      if (ndone[i] < nsteps[i]) begin
         k = ndone[i] + 16'd1;
         ndone[i] = k;
         apply_move(i, lerp(sx[i], ex[i], k, nsteps[i]), lerp(sy[i], ey[i], k, nsteps[i]));
      end else if (gest[i] == GEST_MOVE_RELEASE) begin
         apply_release(i);
      end else if (gest[i] == GEST_MOVE_HOLD) begin
         gest[i] = GEST_HOLD;
      end
   endfunction

   function automatic void predict_events(cmd_t c);
      int n0 = event_q.size();
      run_granted = '0;
      run_nofree = 1'b0;
      if (c.mode == MODE_DOWN) apply_down(c);
      else if (c.slot < NSLOT) begin
         case (c.mode)
            MODE_ADVANCE: apply_advance(c.slot);
            MODE_MOVE:    apply_move(c.slot, c.mx, c.my);
            default:      apply_release(c.slot);
         endcase
      end
      if (event_q.size() > n0) event_q[event_q.size()-1].last = 1'b1;
   endfunction

   // result side: check each word, random stall per word unless steady
   always @(posedge clock) begin
      event_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (event_q.size() == 0) begin
            $error("unexpected word: kind %0d value %0d", rsp_event_kind, rsp_event_value);
            fail_count++;
         end else begin
            e = event_q.pop_front();
            if (rsp_event_kind !== e.kind) begin
               $error("event_kind: expected %0d, got %0d", e.kind, rsp_event_kind);
               fail_count++;
            end
            if (rsp_event_value !== e.value) begin
               $error("event_value: expected %0h, got %0h", e.value, rsp_event_value);
               fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               fail_count++;
            end
            if (rsp_granted_slot !== e.granted) begin
               $error("granted_slot: expected %0d, got %0d", e.granted, rsp_granted_slot);
               fail_count++;
            end
            if (rsp_no_free_slot !== e.nofree) begin
               $error("no_free_slot: expected %0d, got %0d", e.nofree, rsp_no_free_slot);
               fail_count++;
            end
         end
         stall_left = steady ? 0 : $urandom_range(0, 6);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left > 0) stall_left--;
   end

   task automatic send_cmd(cmd_t c);
      int gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= c.mode; req_slot <= c.slot;
      req_begin_x <= c.bx; req_begin_y <= c.by;
      req_target_x <= c.tx; req_target_y <= c.ty;
      req_step_total <= c.steps; req_gesture <= c.gesture;
      req_move_x <= c.mx; req_move_y <= c.my;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cmds_sent++;
      predict_events(c);
   endtask

   task automatic send_down(logic [15:0] bx, by, tx, ty, steps, logic [1:0] g);
      cmd_t c;
      c.mode = MODE_DOWN; c.slot = 4'($urandom_range(0, 15));
      c.bx = bx; c.by = by; c.tx = tx; c.ty = ty; c.steps = steps; c.gesture = g;
      c.mx = 16'($urandom); c.my = 16'($urandom);
      send_cmd(c);
   endtask

   task automatic send_op(mode_type m, logic [3:0] s, logic [15:0] mx = 0, my = 0);
      cmd_t c;
      c.mode = m; c.slot = s;
      c.bx = 16'($urandom); c.by = 16'($urandom);
      c.tx = 16'($urandom); c.ty = 16'($urandom);
      c.steps = 16'($urandom); c.gesture = 2'($urandom);
      c.mx = mx; c.my = my;
      send_cmd(c);
   endtask

   // drop valid, drain, then let any silent command finish
   task automatic settle();
      int guard = 0;
      req_valid <= 1'b0;
      while (event_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_PROTOCOL_KIND) proto = data[0];
      else id_base = data;
   endtask

   task automatic configure(logic p, logic [15:0] base);
      settle();
      write_reg(CSR_PROTOCOL_KIND, {15'd0, p});
      write_reg(CSR_TRACKING_ID_BASE, base);
   endtask

   task automatic test_anon_directed();
      send_down(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd3, GEST_MOVE_RELEASE);
      send_down(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd0, GEST_MOVE_HOLD);
      send_down(16'h1234, 16'h8000, 16'h0001, 16'hFFFE, 16'd5, GEST_HOLD);
      send_down(16'h0100, 16'hF000, 16'h0300, 16'h0010, 16'd1, 2'd3);
      repeat (4) send_op(MODE_ADVANCE, 4'd0);        // three steps, then release
      repeat (2) send_op(MODE_ADVANCE, 4'd1);        // zero steps: hold becomes still
      send_op(MODE_ADVANCE, 4'd2);                   // gesture still: silent
      repeat (2) send_op(MODE_ADVANCE, 4'd3);        // unknown gesture at end: silent
      send_op(MODE_MOVE, 4'd5, 16'hFFFF, 16'h0000);  // move of a free slot
      send_op(MODE_MOVE, 4'd2, 16'h0000, 16'hFFFF);
      send_op(MODE_RELEASE, 4'd7);                   // release of a free slot
      send_op(MODE_ADVANCE, 4'd9);                   // out of range
      send_op(MODE_MOVE, 4'd15, 16'hFFFF, 16'hFFFF);
      send_op(MODE_RELEASE, 4'd12);
      send_op(MODE_RELEASE, 4'd2);
      send_op(MODE_RELEASE, 4'd3);
      send_op(MODE_RELEASE, 4'd1);                   // last contact: button up
   endtask

   task automatic test_slotted_pool();
      configure(1'b1, 16'hFFFF);
      for (int i = 0; i < NSLOT + 1; i++)             // fill, then one with no free slot
         send_down(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 3)), 2'($urandom_range(0, 2)));
      send_op(MODE_RELEASE, 4'd4);
      send_op(MODE_RELEASE, 4'd4);
      send_op(MODE_MOVE, 4'd4, 16'h5555, 16'hAAAA);
      send_op(MODE_MOVE, 4'd8, 16'hAAAA, 16'h5555);
      send_down(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd2, GEST_MOVE_RELEASE);
      configure(PROTO_ANON, 16'h0000);
      send_down(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd1, GEST_MOVE_HOLD);
      send_op(MODE_RELEASE, 4'd0);                   // contact count wraps below zero
   endtask

   function automatic int pick_busy();
      int cand[$];
      for (int i = 0; i < NSLOT; i++) if (busy[i]) cand.push_back(i);
      if (cand.size() == 0) return $urandom_range(0, 15);
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   task automatic random_cmds(int n);
      cmd_t c;
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         c.bx = 16'($urandom); c.by = 16'($urandom);
         c.tx = 16'($urandom); c.ty = 16'($urandom);
         c.mx = 16'($urandom); c.my = 16'($urandom);
         c.slot = 4'($urandom_range(0, 15));
         c.steps = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
         c.gesture = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         if (r < 28) c.mode = MODE_DOWN;
         else if (r < 58) begin c.mode = MODE_ADVANCE; c.slot = 4'(pick_busy()); end
         else if (r < 72) begin c.mode = MODE_MOVE; c.slot = 4'(pick_busy()); end
         else if (r < 90) begin c.mode = MODE_RELEASE; c.slot = 4'(pick_busy()); end
         else begin
            c.mode = mode_type'($urandom_range(0, 3));
            c.steps = 16'($urandom);
         end
         send_cmd(c);
      end
   endtask

   task automatic test_random_settings();
      configure(PROTO_ANON, 16'h0000);
      random_cmds(20);
      configure(1'b1, 16'hFFFF);
      steady = 1;
      random_cmds(20);
      steady = 0;
      configure(PROTO_ANON, 16'($urandom));
      random_cmds(20);
      configure(1'b1, 16'($urandom));
      random_cmds(21);
   endtask

   task automatic test_drain_pause();
      random_cmds(5);
      req_valid <= 1'b0;
      while (event_q.size() != 0) @(posedge clock);
      random_cmds(5);
   endtask

   initial begin
      int guard;
      proto = PROTO_ANON; id_base = '0; contacts = '0;
      for (int i = 0; i < NSLOT; i++) begin busy[i] = 0; gest[i] = GEST_HOLD; end
      reset = 1'b1;
      req_valid = 0; req_mode = 0; req_slot = 0; req_gesture = 0;
      req_begin_x = 0; req_begin_y = 0; req_target_x = 0; req_target_y = 0;
      req_step_total = 0; req_move_x = 0; req_move_y = 0;
      rsp_stall = 0; csr_valid = 0; csr_index = 0; csr_data = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_anon_directed();
      test_slotted_pool();
      test_random_settings();
      test_drain_pause();
      req_valid <= 1'b0;
      guard = 0;
      while (event_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
      if (event_q.size() != 0) begin
         $error("%0d expected words never arrived", event_q.size());
         fail_count++;
      end
      $display("Ran %0d commands over both report protocols; %0d event words checked.",
               cmds_sent, words_checked);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mtgeg_pkg.sv
hw/rtl/mtgeg_div.sv
hw/rtl/mtgeg_dp.sv
hw/rtl/mtgeg_ctrl.sv
hw/rtl/multitouch_gesture_event_generator_core.sv
tb/tb_multitouch_gesture_event_generator_core.sv
